### hdl/cpsp_pkg.sv
// shared types and constants of the constant pool stream parser
`timescale 1ns / 1ps

package cpsp_pkg;

  // result event codes
  localparam logic [1:0] EV_CHUNK = 2'd0;
  localparam logic [1:0] EV_EMPTY = 2'd1;
  localparam logic [1:0] EV_DONE  = 2'd2;

  // constant type bytes that carry chunks
  localparam logic [7:0] TYPE_STRING = 8'd1;
  localparam logic [7:0] TYPE_INT    = 8'd2;
  localparam logic [7:0] TYPE_FLOAT  = 8'd3;

  // one result item as it travels through the result queue
  typedef struct packed {
    logic [1:0]  event_res;
    logic [30:0] constant_index;
    logic [30:0] chunk_index;
    logic [7:0]  type_code;
    logic [31:0] chunk_value;
    logic        last_of_constant;
    logic [31:0] end_offset;
  } res_t;

endpackage

### hdl/cpsp_front.sv
// byte parser: field assembly, counters and classification of each item
`timescale 1ns / 1ps

module cpsp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  logic [7:0]     data_byte,
  input  logic           start_of_file,
  output logic           res_valid,
  output cpsp_pkg::res_t res
);
  import cpsp_pkg::*;

  typedef enum logic [5:0] {
    PH_COUNT   = 6'b000001,
    PH_TYPE    = 6'b000010,
    PH_NCHUNK  = 6'b000100,
    PH_DATA    = 6'b001000,
    PH_PENDING = 6'b010000,
    PH_IDLE    = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_cur, phase_nxt;
  logic [1:0]  bif_r, bif_cur, bif_nxt;
  logic [31:0] word_r, word_cur, word_nxt;
  logic [30:0] cl_r, cl_cur, cl_nxt;
  logic [30:0] cc_r, cc_cur, cc_nxt;
  logic [30:0] chl_r, chl_cur, chl_nxt;
  logic [30:0] ch_r, ch_cur, ch_nxt;
  logic [7:0]  ty_r, ty_cur, ty_nxt;
  logic [31:0] off_r, off_cur, off_nxt;

  logic [31:0] word_sh;
  logic [30:0] count_val;
  logic [30:0] cl_dec;
  logic [30:0] chl_dec;
  logic        ty_known;

  // a start-of-file byte restarts the parser before it is read
  always_comb begin
    if (start_of_file) begin
      phase_cur = PH_COUNT;
      bif_cur   = '0;
      word_cur  = '0;
      cl_cur    = '0;
      cc_cur    = '0;
      chl_cur   = '0;
      ch_cur    = '0;
      ty_cur    = '0;
      off_cur   = '0;
    end else begin
      phase_cur = phase_r;
      bif_cur   = bif_r;
      word_cur  = word_r;
      cl_cur    = cl_r;
      cc_cur    = cc_r;
      chl_cur   = chl_r;
      ch_cur    = ch_r;
      ty_cur    = ty_r;
      off_cur   = off_r;
    end
  end

  // shared helper values
  assign word_sh   = {word_cur[23:0], data_byte};
  assign count_val = word_sh[31] ? '0 : word_sh[30:0];
  assign cl_dec    = (cl_cur != '0) ? cl_cur - 31'd1 : '0;
  assign chl_dec   = (chl_cur != '0) ? chl_cur - 31'd1 : '0;
  assign ty_known  = (ty_cur == TYPE_STRING) || (ty_cur == TYPE_INT) ||
                     (ty_cur == TYPE_FLOAT);

  // next state and result of the current item
  always_comb begin
    phase_nxt = phase_cur;
    bif_nxt   = bif_cur;
    word_nxt  = word_cur;
    cl_nxt    = cl_cur;
    cc_nxt    = cc_cur;
    chl_nxt   = chl_cur;
    ch_nxt    = ch_cur;
    ty_nxt    = ty_cur;
    off_nxt   = off_cur;
    res_valid = 1'b0;
    res       = '0;
    unique case (phase_cur)
      PH_COUNT: begin
        word_nxt = word_sh;
        off_nxt  = off_cur + 32'd1;
        bif_nxt  = bif_cur + 2'd1;
        if (bif_cur == 2'd3) begin
          word_nxt = '0;
          cl_nxt   = count_val;
          cc_nxt   = '0;
          if (count_val == '0) begin
            phase_nxt      = PH_IDLE;
            res_valid      = 1'b1;
            res.event_res  = EV_DONE;
            res.end_offset = off_nxt;
          end else begin
            phase_nxt = PH_TYPE;
          end
        end
      end
      PH_TYPE: begin
        ty_nxt    = data_byte;
        off_nxt   = off_cur + 32'd1;
        bif_nxt   = '0;
        word_nxt  = '0;
        phase_nxt = PH_NCHUNK;
      end
      PH_NCHUNK: begin
        word_nxt = word_sh;
        off_nxt  = off_cur + 32'd1;
        bif_nxt  = bif_cur + 2'd1;
        if (bif_cur == 2'd3) begin
          word_nxt = '0;
          chl_nxt  = count_val;
          ch_nxt   = '0;
          if ((count_val == '0) || !ty_known) begin
            // empty or unknown constant: one result, then the next constant or the completion
            res_valid            = 1'b1;
            res.event_res        = EV_EMPTY;
            res.constant_index   = cc_cur;
            res.type_code        = ty_cur;
            res.last_of_constant = 1'b1;
            cl_nxt               = cl_dec;
            cc_nxt               = cc_cur + 31'd1;
            phase_nxt            = (cl_dec != '0) ? PH_TYPE : PH_PENDING;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        off_nxt = off_cur + 32'd1;
        if (ty_cur != TYPE_STRING) begin
          word_nxt = word_sh;
          bif_nxt  = bif_cur + 2'd1;
        end
        if ((ty_cur == TYPE_STRING) || (bif_cur == 2'd3)) begin
          if (ty_cur != TYPE_STRING) begin
            word_nxt = '0;
          end
          res_valid            = 1'b1;
          res.event_res        = EV_CHUNK;
          res.constant_index   = cc_cur;
          res.chunk_index      = ch_cur;
          res.type_code        = ty_cur;
          res.chunk_value      = (ty_cur == TYPE_STRING) ? {24'd0, data_byte} : word_sh;
          res.last_of_constant = (chl_dec == '0);
          chl_nxt              = chl_dec;
          ch_nxt               = ch_cur + 31'd1;
          if (chl_dec == '0) begin
            cl_nxt    = cl_dec;
            cc_nxt    = cc_cur + 31'd1;
            phase_nxt = (cl_dec != '0) ? PH_TYPE : PH_PENDING;
          end
        end
      end
      PH_PENDING: begin
        // completion takes this item's slot without reading its byte
        phase_nxt      = PH_IDLE;
        res_valid      = 1'b1;
        res.event_res  = EV_DONE;
        res.end_offset = off_cur;
      end
      PH_IDLE: begin
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // parser state, advanced once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COUNT;
      bif_r   <= '0;
      word_r  <= '0;
      cl_r    <= '0;
      cc_r    <= '0;
      chl_r   <= '0;
      ch_r    <= '0;
      ty_r    <= '0;
      off_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      bif_r   <= bif_nxt;
      word_r  <= word_nxt;
      cl_r    <= cl_nxt;
      cc_r    <= cc_nxt;
      chl_r   <= chl_nxt;
      ch_r    <= ch_nxt;
      ty_r    <= ty_nxt;
      off_r   <= off_nxt;
    end
  end

endmodule

### hdl/cpsp_fifo.sv
// result queue between the byte parser and the result ports
`timescale 1ns / 1ps

module cpsp_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  cpsp_pkg::res_t wr_data,
  input  logic           rd_en,
  output cpsp_pkg::res_t rd_data,
  output logic           full,
  output logic           empty
);
  import cpsp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CW'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hdl/constant_pool_stream_parser_top.sv
// top level of the constant pool stream parser
`timescale 1ns / 1ps

// Takes a constant pool one byte per cycle: an item is taken at every edge with push high
// and full low, so the sustained rate is one byte per clock, set by the state update of
// the byte parser. A result enters the queue at the edge that takes its byte and shows on
// the out_ ports from the next cycle if the queue held nothing, else after those ahead of
// it are popped. full rises only when the queue of RESULT_DEPTH results is full because
// the far side is not popping; bytes that give no result are then held back as well. A
// start_of_file byte restarts the parser and is read as the constant count's first byte.
module constant_pool_stream_parser_top #(
  parameter int RESULT_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_file,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_event_res,
  output logic [30:0] out_constant_index,
  output logic [30:0] out_chunk_index,
  output logic [7:0]  out_type_code,
  output logic [31:0] out_chunk_value,
  output logic        out_last_of_constant,
  output logic [31:0] out_end_offset
);
  import cpsp_pkg::*;

  logic take;
  logic res_valid;
  res_t res;
  res_t head;

  assign take = push && !full;

  // byte parser
  cpsp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .data_byte     (in_data_byte),
    .start_of_file (in_start_of_file),
    .res_valid     (res_valid),
    .res           (res)
  );

  // result queue
  cpsp_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (take && res_valid),
    .wr_data (res),
    .rd_en   (pop && !empty),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  // result ports
  assign out_event_res        = head.event_res;
  assign out_constant_index   = head.constant_index;
  assign out_chunk_index      = head.chunk_index;
  assign out_type_code        = head.type_code;
  assign out_chunk_value      = head.chunk_value;
  assign out_last_of_constant = head.last_of_constant;
  assign out_end_offset       = head.end_offset;

endmodule

### hdl/cpsp_checker.sv
// port-level checks of the constant pool stream parser, bound to the top level
`timescale 1ns / 1ps

module cpsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  out_event_res,
  input logic [30:0] out_constant_index,
  input logic [30:0] out_chunk_index,
  input logic [7:0]  out_type_code,
  input logic [31:0] out_chunk_value,
  input logic        out_last_of_constant,
  input logic [31:0] out_end_offset
);
  import cpsp_pkg::*;

  // reset leaves the result queue empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // a completion carries only the end offset
  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_event_res == EV_DONE) |->
      (out_constant_index == '0 && out_chunk_index == '0 && out_type_code == '0 &&
       out_chunk_value == '0 && !out_last_of_constant))
    else $error("completion result with stray fields");

  // an empty constant is a single closing result with no value
  a_empty_const: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_event_res == EV_EMPTY) |->
      (out_last_of_constant && out_chunk_index == '0 && out_chunk_value == '0 &&
       out_end_offset == '0))
    else $error("malformed empty-constant result");

  // string chunks are single bytes and chunks carry no offset
  a_chunk_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_event_res == EV_CHUNK) |->
      (out_end_offset == '0 &&
       (out_type_code != TYPE_STRING || out_chunk_value[31:8] == '0)))
    else $error("malformed chunk result");

  // a shown result stays until it is popped
  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_event_res) && $stable(out_chunk_value)))
    else $error("waiting result changed before pop");

endmodule

bind constant_pool_stream_parser_top cpsp_checker u_cpsp_checker (.*);
